// ===== rtl/rational_arithmetic_unit_macros.svh =====
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Assert that a condition implies another in the same cycle
`define RAU_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Assert that a condition implies another in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/rau_pkg.sv =====
// Shared types, constants and command codes for the rational arithmetic unit
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_LT  = 3'd4;
    localparam logic [2:0] CMD_EQ  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]                   command;
        logic signed [FIELD_BITS-1:0] a_num;
        logic signed [FIELD_BITS-1:0] a_den;
        logic signed [FIELD_BITS-1:0] b_num;
        logic signed [FIELD_BITS-1:0] b_den;
    } request_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] res_num;
        logic signed [FIELD_BITS-1:0] res_den;
        logic                         compare_true;
        logic [1:0]                   status;
    } result_t;

endpackage

// ===== rtl/rau_mul.sv =====
// Shared signed multiplier with a registered product
module rau_mul #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic signed [WORD_BITS-1:0]   op_a,
    input  logic signed [WORD_BITS-1:0]   op_b,
    output logic signed [2*WORD_BITS-1:0] prod
);

    logic signed [2*WORD_BITS-1:0] prod_reg;

    // Register each product
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*WORD_BITS)'(op_a) * (2*WORD_BITS)'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/rau_div.sv =====
// Restoring radix-2 divider for unsigned wide operands, one bit per cycle
module rau_div #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2*WORD_BITS-1:0]      dividend,
    input  logic [2*WORD_BITS-1:0]      divisor,
    output logic                        done,
    output logic [2*WORD_BITS-1:0]      quotient,
    output logic [2*WORD_BITS-1:0]      remainder
);

    localparam int W  = 2*WORD_BITS;
    localparam int CW = $clog2(W+1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    // Shift one dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier and divider
//
// One request at a time: busy rises on the cycle after start and falls when the result
// strobe fires. Compare and spare requests, and arithmetic requests with a zero
// denominator or a zero numerator, go through the multiply and form states and then
// from the GCD state straight to the output state, which strobes the result. Other
// arithmetic requests run Euclid's algorithm on the shared bit-serial divider (each
// remainder step issues the divider, shifts in all 2*WORD_BITS dividend bits and waits
// for its done strobe; up to about 90 steps at 32 bits) and then two exact divisions of
// the same length, so the latency is set by the divider and the number of GCD steps.
// The result is on result for one cycle with done high; the receiver cannot stall it.
module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rau_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output rau_pkg::result_t  result
);

    `include "rational_arithmetic_unit_macros.svh"

    localparam int W  = WORD_BITS;
    localparam int W2 = 2*WORD_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M1    = 4'd1;
    localparam logic [3:0] S_M2    = 4'd2;
    localparam logic [3:0] S_M3    = 4'd3;
    localparam logic [3:0] S_M4    = 4'd4;
    localparam logic [3:0] S_FORM  = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_GWAIT = 4'd7;
    localparam logic [3:0] S_DN    = 4'd8;
    localparam logic [3:0] S_DNW   = 4'd9;
    localparam logic [3:0] S_DD    = 4'd10;
    localparam logic [3:0] S_DDW   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] cmd_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W2-1:0] p0_reg, p1_reg, p2_reg;
    logic [W2-1:0] nmag_reg, dmag_reg, gx_reg, gy_reg;
    logic nneg_reg;
    logic signed [W-1:0] ma, mb;
    logic signed [W2-1:0] prod;
    logic dv_start;
    logic dv_done;
    logic [W2-1:0] dv_a, dv_b, dv_q, dv_r;
    rau_pkg::result_t out_reg;
    logic done_reg;
    logic busy_reg;

    rau_mul #(.WORD_BITS(W)) u_mul (.clk(clk), .op_a(ma), .op_b(mb), .prod(prod));

    rau_div #(.WORD_BITS(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
        .done(dv_done), .quotient(dv_q), .remainder(dv_r)
    );

    // Multiplier operand select per sequencer step
    always_comb
    begin
        ma = an_reg;
        mb = bd_reg;
        unique case (state_reg)
            S_M1:    begin ma = an_reg; mb = (cmd_reg == rau_pkg::CMD_MUL) ? bn_reg : bd_reg; end
            S_M2:    begin ma = ad_reg; mb = (cmd_reg == rau_pkg::CMD_DIV) ? bn_reg : bd_reg; end
            S_M3:    begin ma = ad_reg; mb = bn_reg; end
            default: begin ma = an_reg; mb = bd_reg; end
        endcase
    end

    function automatic logic [W2-1:0] mag(input logic signed [W2-1:0] v);
        mag = v[W2-1] ? W2'(-v) : W2'(v);
    endfunction

    // Combinational helpers for the form step
    logic [W2-1:0] pm, qm, sum_mag, dm;
    logic pn, qn, sum_neg, is_sum, lt_raw;
    logic signed [W2-1:0] qv;
    logic [W2-1:0] lim;
    logic nfit, dfit;
    logic signed [W-1:0] nres;

    always_comb
    begin
        is_sum = (cmd_reg == rau_pkg::CMD_ADD) || (cmd_reg == rau_pkg::CMD_SUB);
        qv     = (cmd_reg == rau_pkg::CMD_SUB) ? -p2_reg : p2_reg;
        pn     = p0_reg[W2-1];
        qn     = qv[W2-1];
        pm     = mag(p0_reg);
        qm     = mag(qv);
        if (!is_sum)
        begin
            sum_neg = pn;
            sum_mag = pm;
        end
        else if (pn == qn)
        begin
            sum_neg = pn;
            sum_mag = pm + qm;
        end
        else if (pm >= qm)
        begin
            sum_neg = pn;
            sum_mag = pm - qm;
        end
        else
        begin
            sum_neg = qn;
            sum_mag = qm - pm;
        end
        if (p1_reg[W2-1])
            sum_neg = !sum_neg;
        if (sum_mag == '0)
            sum_neg = 1'b0;
        dm = mag(p1_reg);
        // p0 = an*bd, p2 = ad*bn for compare
        lt_raw = ((ad_reg[W-1] != bd_reg[W-1]) ? (p2_reg < p0_reg) : (p0_reg < p2_reg));
        lim  = W2'(1) << (W-1);
        nfit = nneg_reg ? (nmag_reg <= lim) : (nmag_reg < lim);
        dfit = dmag_reg < lim;
        nres = nneg_reg ? W'(-nmag_reg) : W'(nmag_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        dv_start   = 1'b0;
        dv_a       = gx_reg;
        dv_b       = gy_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_FORM;
            S_FORM:  state_next = S_GCD;
            S_GCD:
            begin
                if (cmd_reg > rau_pkg::CMD_DIV || dmag_reg == '0 || nmag_reg == '0)
                    state_next = S_OUT;
                else if (gy_reg == '0)
                    state_next = S_DN;
                else
                begin
                    dv_start   = 1'b1;
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT: if (dv_done) state_next = S_GCD;
            S_DN:
            begin
                dv_start   = 1'b1;
                dv_a       = nmag_reg;
                state_next = S_DNW;
            end
            S_DNW:   if (dv_done) state_next = S_DD;
            S_DD:
            begin
                dv_start   = 1'b1;
                dv_a       = dmag_reg;
                state_next = S_DDW;
            end
            S_DDW:   if (dv_done) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DN || state_reg == S_DD)
            dv_b = gx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= request.command;
                an_reg  <= W'(request.a_num);
                ad_reg  <= W'(request.a_den);
                bn_reg  <= W'(request.b_num);
                bd_reg  <= W'(request.b_den);
            end
            S_M2: p0_reg <= prod;
            S_M3: p1_reg <= prod;
            S_M4: p2_reg <= prod;
            S_FORM:
            begin
                nneg_reg <= sum_neg;
                nmag_reg <= sum_mag;
                dmag_reg <= dm;
                gx_reg   <= sum_mag;
                gy_reg   <= dm;
            end
            S_GWAIT:
            begin
                if (dv_done)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= dv_r;
                end
            end
            S_DNW: if (dv_done) nmag_reg <= dv_q;
            S_DDW: if (dv_done) dmag_reg <= dv_q;
            S_OUT:
            begin
                out_reg <= '0;
                if (cmd_reg <= rau_pkg::CMD_DIV)
                begin
                    if (dmag_reg == '0)
                        out_reg.status <= rau_pkg::ST_ZERO_DEN;
                    else if (!nfit || !dfit)
                        out_reg.status <= rau_pkg::ST_OVERFLOW;
                    else
                    begin
                        out_reg.res_num <= 32'(nres);
                        out_reg.res_den <= 32'(dmag_reg);
                    end
                end
                else if (cmd_reg == rau_pkg::CMD_LT)
                begin
                    if (ad_reg == '0 || bd_reg == '0)
                        out_reg.status <= rau_pkg::ST_ZERO_DEN;
                    else
                        out_reg.compare_true <= lt_raw;
                end
                else if (cmd_reg == rau_pkg::CMD_EQ)
                    out_reg.compare_true <= (an_reg == bn_reg) && (ad_reg == bd_reg);
            end
            default: ;
        endcase
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = out_reg;

    `RAU_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done, !busy)
    `RAU_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `RAU_ASSERT_IMPL(a_den_pos, clk, rst_n, done && result.status == rau_pkg::ST_OK,
        !result.res_den[31])

endmodule

// ===== bench/rational_arithmetic_unit_tb.sv =====
// Self-checking bench for the rational arithmetic unit: directed table plus random requests
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_REQUESTS = 800;
    localparam int STALL_LIMIT     = 40000;
    localparam int DRAIN_CYCLES    = 50;

    typedef struct {
        rau_pkg::request_t req;
        bit                typed;
        rau_pkg::result_t  want;
    } table_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    rau_pkg::request_t request;
    logic              busy;
    logic              done;
    rau_pkg::result_t  result;

    rau_pkg::result_t pending_results[$];
    table_row_t       stim_table[$];
    int               mismatches;
    int               results_seen;
    int               requests_sent;
    int               idle_cycles;
    int               cmd_hits[8];

    rational_arithmetic_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Magnitude of a signed 64-bit product
    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // Compute the expected result for one request: the reduced rational or the compare flag
    function automatic rau_pkg::result_t compute_rational(rau_pkg::request_t r);
        longint           an, ad, bn, bd, p, q, d, lhs, rhs;
        logic [63:0]      pm, qm, nmag, dmag, x, y, t, lim;
        logic [63:0]      nval;
        bit               nneg, nfit;
        rau_pkg::result_t o;
        an = longint'(r.a_num);
        ad = longint'(r.a_den);
        bn = longint'(r.b_num);
        bd = longint'(r.b_den);
        o = '0;
        if (r.command inside {rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL,
                              rau_pkg::CMD_DIV})
        begin
            if (r.command == rau_pkg::CMD_ADD || r.command == rau_pkg::CMD_SUB)
            begin
                p = an * bd;
                q = ad * ((r.command == rau_pkg::CMD_SUB) ? -bn : bn);
                pm = magnitude(p);
                qm = magnitude(q);
                if ((p < 0) == (q < 0))
                begin
                    nneg = (p < 0);
                    nmag = pm + qm;
                end
                else if (pm >= qm)
                begin
                    nneg = (p < 0);
                    nmag = pm - qm;
                end
                else
                begin
                    nneg = (q < 0);
                    nmag = qm - pm;
                end
                d = ad * bd;
            end
            else
            begin
                p = (r.command == rau_pkg::CMD_MUL) ? an * bn : an * bd;
                nneg = (p < 0);
                nmag = magnitude(p);
                d = (r.command == rau_pkg::CMD_MUL) ? ad * bd : ad * bn;
            end
            if (d < 0)
                nneg = !nneg;
            dmag = magnitude(d);
            if (nmag == 0)
                nneg = 1'b0;
            if (dmag == 0)
                o.status = rau_pkg::ST_ZERO_DEN;
            else
            begin
                // Reduce by Euclid's algorithm; a zero numerator keeps its denominator
                if (nmag != 0)
                begin
                    x = nmag;
                    y = dmag;
                    while (y != 0)
                    begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    nmag = nmag / x;
                    dmag = dmag / x;
                end
                lim = 64'd1 << 31;
                nfit = nneg ? (nmag <= lim) : (nmag < lim);
                if (!nfit || dmag >= lim)
                    o.status = rau_pkg::ST_OVERFLOW;
                else
                begin
                    nval = nneg ? 64'd0 - nmag : nmag;
                    o.res_num = nval[31:0];
                    o.res_den = dmag[31:0];
                end
            end
        end
        else if (r.command == rau_pkg::CMD_LT)
        begin
            if (ad == 0 || bd == 0)
                o.status = rau_pkg::ST_ZERO_DEN;
            else
            begin
                lhs = an * bd;
                rhs = bn * ad;
                o.compare_true = ((ad < 0) != (bd < 0)) ? (rhs < lhs) : (lhs < rhs);
            end
        end
        else if (r.command == rau_pkg::CMD_EQ)
            o.compare_true = (an == bn && ad == bd);
        return o;
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // Append a directed row; typed rows carry their expected result
    task automatic add_row(logic [2:0] cmd, int an, int ad, int bn, int bd,
                           bit typed, rau_pkg::result_t want);
        table_row_t row;
        row.req.command = cmd;
        row.req.a_num = an;
        row.req.a_den = ad;
        row.req.b_num = bn;
        row.req.b_den = bd;
        row.typed = typed;
        row.want = want;
        stim_table.push_back(row);
    endtask

    // Offer one request and hold it until the unit takes it
    task automatic send_request(rau_pkg::request_t r, rau_pkg::result_t want);
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(want);
        cmd_hits[r.command]++;
        requests_sent++;
    endtask

    // Drop start for a number of cycles
    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Pick an operand value: small, full range or extreme
    function automatic int pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return $urandom_range(0, 80) - 40;
        else if (mode < 8)
            return int'($urandom);
        else
            case ($urandom_range(0, 4))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
    endfunction

    // Pick a denominator, rarely zero
    function automatic int pick_den();
        int v;
        if ($urandom_range(0, 29) == 0)
            return 0;
        v = pick_value();
        return (v == 0) ? 1 : v;
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        rau_pkg::result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t result with nothing expected", $realtime);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.res_num !== want.res_num)
                    report_mismatch("res_num", result.res_num, want.res_num);
                if (result.res_den !== want.res_den)
                    report_mismatch("res_den", result.res_den, want.res_den);
                if (result.compare_true !== want.compare_true)
                    report_mismatch("compare_true", result.compare_true, want.compare_true);
                if (result.status !== want.status)
                    report_mismatch("status", result.status, want.status);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
            $display("[rational_arithmetic_unit] ERROR");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin
        rau_pkg::result_t  none;
        rau_pkg::result_t  want;
        rau_pkg::request_t r;
        int                burst_left;
        int                drain;
        none = '0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        idle_cycles = 0;
        foreach (cmd_hits[i])
            cmd_hits[i] = 0;
        start <= 1'b0;
        request <= '0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        add_row(rau_pkg::CMD_ADD, 1, 2, 1, 3, 0, none);
        add_row(rau_pkg::CMD_SUB, 1, 2, 1, 2, 0, none);
        add_row(rau_pkg::CMD_MUL, 32'sh7fffffff, 1, 32'sh7fffffff, 1, 1,
                '{0, 0, 0, rau_pkg::ST_OVERFLOW});
        add_row(rau_pkg::CMD_MUL, 32'sh80000000, 1, 32'sh80000000, 1, 1,
                '{0, 0, 0, rau_pkg::ST_OVERFLOW});
        add_row(rau_pkg::CMD_DIV, 1, 2, 0, 3, 1, '{0, 0, 0, rau_pkg::ST_ZERO_DEN});
        add_row(rau_pkg::CMD_ADD, 5, 0, 1, 3, 1, '{0, 0, 0, rau_pkg::ST_ZERO_DEN});
        add_row(rau_pkg::CMD_DIV, -3, 4, 5, -6, 0, none);
        add_row(rau_pkg::CMD_LT, 1, 2, 1, 0, 1, '{0, 0, 0, rau_pkg::ST_ZERO_DEN});
        add_row(rau_pkg::CMD_LT, 1, -2, 1, 3, 0, none);
        add_row(rau_pkg::CMD_LT, -7, -3, 2, 5, 0, none);
        add_row(rau_pkg::CMD_EQ, 3, 7, 3, 7, 1, '{0, 0, 1, rau_pkg::ST_OK});
        add_row(rau_pkg::CMD_EQ, 1, 2, 2, 4, 1, '{0, 0, 0, rau_pkg::ST_OK});
        add_row(CMD_SPARE_LO, 9, 4, 3, 2, 1, '{0, 0, 0, rau_pkg::ST_OK});
        add_row(CMD_SPARE_HI, 32'sh80000000, 0, -1, 32'sh7fffffff, 1,
                '{0, 0, 0, rau_pkg::ST_OK});
        add_row(rau_pkg::CMD_ADD, 32'sh80000000, 1, 32'sh80000000, 1, 1,
                '{0, 0, 0, rau_pkg::ST_OVERFLOW});
        add_row(rau_pkg::CMD_MUL, 32'sh80000000, 1, 1, 1, 1,
                '{32'sh80000000, 1, 0, rau_pkg::ST_OK});
        add_row(rau_pkg::CMD_DIV, 32'sh80000000, 1, -1, 1, 1,
                '{0, 0, 0, rau_pkg::ST_OVERFLOW});
        add_row(rau_pkg::CMD_SUB, 123456789, 987654, -55555, 32'sh7ffffffe, 0, none);
        add_row(rau_pkg::CMD_MUL, 0, -5, 3, 7, 1, '{0, 35, 0, rau_pkg::ST_OK});
        add_row(rau_pkg::CMD_MUL, 1, 32'sh7fffffff, 1, 32'sh7fffffff, 1,
                '{0, 0, 0, rau_pkg::ST_OVERFLOW});
        add_row(rau_pkg::CMD_LT, 2, 4, 1, 2, 0, none);
        add_row(rau_pkg::CMD_DIV, 32'sh7fffffff, -1, 32'sh80000000, 32'sh80000000, 0, none);
        foreach (stim_table[i])
        begin
            want = stim_table[i].typed ? stim_table[i].want
                                       : compute_rational(stim_table[i].req);
            send_request(stim_table[i].req, want);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 4));
        end

        // Random requests in bursts with gaps
        burst_left = $urandom_range(1, 20);
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // Hold off until the unit has delivered everything
            if ((n == RANDOM_REQUESTS / 2 || $urandom_range(0, 199) == 0) &&
                pending_results.size() != 0)
            begin
                start <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 99) < 4)
                r.command = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            else
                r.command = 3'($urandom_range(rau_pkg::CMD_ADD, rau_pkg::CMD_EQ));
            r.a_num = pick_value();
            r.a_den = pick_den();
            r.b_num = pick_value();
            r.b_den = pick_den();
            if (r.command == rau_pkg::CMD_EQ && $urandom_range(0, 1))
            begin
                r.b_num = r.a_num;
                r.b_den = r.a_den;
            end
            send_request(r, compute_rational(r));
            burst_left--;
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
        end
        start <= 1'b0;

        // Drain outstanding results
        drain = 0;
        while (pending_results.size() != 0 && drain < STALL_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            mismatches++;
        end

        $display("Sent %0d requests (%0d table rows), checked %0d results, %0d mismatches",
                 requests_sent, stim_table.size(), results_seen, mismatches);
        $display("Per command: add %0d sub %0d mul %0d div %0d lt %0d eq %0d spare %0d",
                 cmd_hits[rau_pkg::CMD_ADD], cmd_hits[rau_pkg::CMD_SUB],
                 cmd_hits[rau_pkg::CMD_MUL], cmd_hits[rau_pkg::CMD_DIV],
                 cmd_hits[rau_pkg::CMD_LT], cmd_hits[rau_pkg::CMD_EQ],
                 cmd_hits[CMD_SPARE_LO] + cmd_hits[CMD_SPARE_HI]);
        if (mismatches == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule

// ===== rational_arithmetic_unit.f =====
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_mul.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
